### rtl/core/sps_pkg.sv
`default_nettype none

package sps_pkg;

    localparam int FIELD_W         = 16;
    localparam int LEVEL_W         = 16;
    localparam int MORTON_W        = 48;
    localparam int IDX_W           = 3;
    localparam int NUM_AXES        = 3;
    localparam int NUM_SUB         = 8;
    localparam int COORD_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        ACT_OCT  = 2'd0,
        ACT_QUAD = 2'd1,
        ACT_BIN  = 2'd2
    } t_action;

    // One box, fully prepared for the output serializer.
    typedef struct packed {
        t_action                                  action;
        logic [NUM_AXES-1:0][FIELD_W-1:0]         start;
        logic [NUM_AXES-1:0][FIELD_W-1:0]         start_hi;
        logic [NUM_AXES-1:0][FIELD_W-1:0]         len;
        logic [NUM_AXES-1:0][FIELD_W-1:0]         first;
        logic [NUM_AXES-1:0][FIELD_W-1:0]         second;
        logic [MORTON_W-1:0]                      base;
        logic [LEVEL_W-1:0]                       level;
        logic [NUM_SUB-1:0][MORTON_W-1:0]         vol;
    } t_box;

    // Axes cut by a split mode: bit0 x, bit1 y, bit2 z.
    function automatic logic [NUM_AXES-1:0] split_axes(input t_action act);
        logic [NUM_AXES-1:0] s;
        case (act)
            ACT_OCT:  s = 3'b111;
            ACT_QUAD: s = 3'b011;
            ACT_BIN:  s = 3'b100;
            default:  s = 3'b000;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/core/sps_emit.sv
`default_nettype none

module sps_emit
    import sps_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire t_box                i_box,
    output logic                     o_free,
    output logic                     o_strobe,
    output logic [IDX_W-1:0]         o_subset_index,
    output logic [FIELD_W-1:0]       o_sub_start_x,
    output logic [FIELD_W-1:0]       o_sub_start_y,
    output logic [FIELD_W-1:0]       o_sub_start_z,
    output logic [FIELD_W-1:0]       o_sub_length_x,
    output logic [FIELD_W-1:0]       o_sub_length_y,
    output logic [FIELD_W-1:0]       o_sub_length_z,
    output logic [MORTON_W-1:0]      o_sub_morton,
    output logic [LEVEL_W-1:0]       o_sub_level,
    output logic                     o_last
);

    logic                r_valid;
    logic [IDX_W-1:0]    r_k;
    t_box                r_box;
    logic [MORTON_W-1:0] r_mort;

    logic [IDX_W-1:0]    n_k;
    logic [MORTON_W-1:0] n_mort;
    logic [IDX_W-1:0]    last_k;
    logic [IDX_W-1:0]    idx;
    logic [NUM_AXES-1:0] split;
    logic                load;
    logic [NUM_AXES-1:0][FIELD_W-1:0] st;
    logic [NUM_AXES-1:0][FIELD_W-1:0] ln;

    always_comb begin
        case (r_box.action)
            ACT_OCT:  last_k = 3'd7;
            ACT_QUAD: last_k = 3'd3;
            ACT_BIN:  last_k = 3'd1;
            default:  last_k = 3'd0;
        endcase
    end

    // Binary z mode walks the two z halves only.
    assign idx    = (r_box.action == ACT_BIN) ? {r_k[0], 2'b00} : r_k;
    assign split  = split_axes(r_box.action);
    assign o_free = !r_valid || (r_k == last_k);
    assign load   = i_valid && o_free;
    assign n_k    = r_k + 3'd1;
    assign n_mort = r_mort + r_box.vol[idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_k     <= '0;
        end else if (o_free) begin
            r_valid <= 1'b0;
        end else begin
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_box  <= i_box;
            r_mort <= i_box.base;
        end else if (r_valid) begin
            r_mort <= n_mort;
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (!split[a]) begin
                st[a] = r_box.start[a];
                ln[a] = r_box.len[a];
            end else if (idx[a]) begin
                st[a] = r_box.start_hi[a];
                ln[a] = r_box.second[a];
            end else begin
                st[a] = r_box.start[a];
                ln[a] = r_box.first[a];
            end
        end
    end

    assign o_strobe       = r_valid;
    assign o_last         = r_valid && (r_k == last_k);
    assign o_subset_index = idx;
    assign o_sub_start_x  = st[0];
    assign o_sub_start_y  = st[1];
    assign o_sub_start_z  = st[2];
    assign o_sub_length_x = ln[0];
    assign o_sub_length_y = ln[1];
    assign o_sub_length_z = ln[2];
    assign o_sub_morton   = (r_box.action == ACT_OCT) ? r_mort : '0;
    assign o_sub_level    = r_box.level;

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_k <= last_k))
        else $error("sub-box counter ran past the last sub-box");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last && !load) |=> (o_strobe && (r_k == $past(r_k) + 3'd1)))
        else $error("split ended before its last sub-box");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_strobe && (r_k == '0)))
        else $error("loaded box did not start at sub-box zero");

    a_bin_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (r_box.action == ACT_BIN)) |->
            ((o_subset_index == 3'd0) || (o_subset_index == 3'd4)))
        else $error("binary split gave an x or y half");

    a_no_load_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> !load)
        else $error("new box loaded over an unfinished split");

endmodule

`default_nettype wire

### rtl/core/set_partition_octree_split.sv
// Splits one 3D box per request into 8 (octree), 4 (quad x/y) or 2 (binary z)
// sub-boxes, delivered one per cycle on o_strobe with o_last on the final one;
// action code 3 is taken and dropped without results. A request passes
// through three prep stages (halving, x*y products and start sums, volumes)
// and then the serializer, which sets the sustained rate of boxes. A request
// may be issued in every cycle that busy is low, so boxes queue in the prep
// stages while the serializer drains the previous split with no idle cycle in
// between. The results cannot be held off; busy rises only when all prep
// stages are full.
`default_nettype none

module set_partition_octree_split
    import sps_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_action,
    input  wire logic [FIELD_W-1:0]  i_start_x,
    input  wire logic [FIELD_W-1:0]  i_start_y,
    input  wire logic [FIELD_W-1:0]  i_start_z,
    input  wire logic [FIELD_W-1:0]  i_length_x,
    input  wire logic [FIELD_W-1:0]  i_length_y,
    input  wire logic [FIELD_W-1:0]  i_length_z,
    input  wire logic [MORTON_W-1:0] i_morton_base,
    input  wire logic [LEVEL_W-1:0]  i_level,
    output logic                     o_strobe,
    output logic [IDX_W-1:0]         o_subset_index,
    output logic [FIELD_W-1:0]       o_sub_start_x,
    output logic [FIELD_W-1:0]       o_sub_start_y,
    output logic [FIELD_W-1:0]       o_sub_start_z,
    output logic [FIELD_W-1:0]       o_sub_length_x,
    output logic [FIELD_W-1:0]       o_sub_length_y,
    output logic [FIELD_W-1:0]       o_sub_length_z,
    output logic [MORTON_W-1:0]      o_sub_morton,
    output logic [LEVEL_W-1:0]       o_sub_level,
    output logic                     o_last
);

    // Coordinates live in the narrower of the port width and COORD_WIDTH.
    localparam int CW  = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int PW  = 2 * CW;
    localparam int VW  = 3 * CW;

    typedef struct packed {
        t_action                          action;
        logic [NUM_AXES-1:0][FIELD_W-1:0] start;
        logic [NUM_AXES-1:0][FIELD_W-1:0] len;
        logic [NUM_AXES-1:0][FIELD_W-1:0] first;
        logic [NUM_AXES-1:0][FIELD_W-1:0] second;
        logic [MORTON_W-1:0]              base;
        logic [LEVEL_W-1:0]               level;
    } t_stage_a;

    typedef struct packed {
        t_action                          action;
        logic [NUM_AXES-1:0][FIELD_W-1:0] start;
        logic [NUM_AXES-1:0][FIELD_W-1:0] start_hi;
        logic [NUM_AXES-1:0][FIELD_W-1:0] len;
        logic [NUM_AXES-1:0][FIELD_W-1:0] first;
        logic [NUM_AXES-1:0][FIELD_W-1:0] second;
        logic [MORTON_W-1:0]              base;
        logic [LEVEL_W-1:0]               level;
        logic [3:0][PW-1:0]               pxy;
    } t_stage_b;

    logic     r_a_valid, r_b_valid, r_c_valid;
    t_stage_a r_a;
    t_stage_b r_b;
    t_box     r_c;

    t_stage_a n_a;
    t_stage_b n_b;
    t_box     n_c;

    logic accept, code_ok;
    logic a_adv, b_adv, c_adv;
    logic e_free;

    logic [NUM_AXES-1:0][FIELD_W-1:0] in_start, in_len;
    logic [NUM_AXES-1:0]              b_split;
    logic [1:0]                       lev_inc;
    logic [CW-1:0]                    hi_sum;
    logic [CW-1:0]                    mx, my, mz;

    // Back-pressure: each stage moves when the one after it frees up.
    assign c_adv  = !r_c_valid || e_free;
    assign b_adv  = !r_b_valid || c_adv;
    assign a_adv  = !r_a_valid || b_adv;
    assign busy   = !a_adv;
    assign accept = start && !busy;

    always_comb begin
        code_ok = i_action inside {ACT_OCT, ACT_QUAD, ACT_BIN};
    end

    assign in_start = {i_start_z, i_start_y, i_start_x};
    assign in_len   = {i_length_z, i_length_y, i_length_x};

    // Stage A: mask to coordinate width, halve each extent.
    always_comb begin
        n_a.action = t_action'(i_action);
        n_a.base   = i_morton_base;
        n_a.level  = i_level;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_a.start[a]  = FIELD_W'(in_start[a][CW-1:0]);
            n_a.len[a]    = FIELD_W'(in_len[a][CW-1:0]);
            n_a.second[a] = n_a.len[a] >> 1;
            n_a.first[a]  = n_a.len[a] - n_a.second[a];
        end
    end

    // Stage B: upper-half starts, new level, x*y areas of the four quadrants.
    always_comb begin
        b_split    = split_axes(r_a.action);
        lev_inc    = '0;
        hi_sum     = '0;
        mx         = '0;
        my         = '0;
        n_b.action = r_a.action;
        n_b.start  = r_a.start;
        n_b.len    = r_a.len;
        n_b.first  = r_a.first;
        n_b.second = r_a.second;
        n_b.base   = r_a.base;
        for (int a = 0; a < NUM_AXES; a++) begin
            hi_sum          = r_a.start[a][CW-1:0] + r_a.first[a][CW-1:0];
            n_b.start_hi[a] = FIELD_W'(hi_sum);
            if (b_split[a] && (r_a.second[a] != '0)) begin
                lev_inc = lev_inc + 2'd1;
            end
        end
        n_b.level = r_a.level + LEVEL_W'(lev_inc);
        for (int j = 0; j < 4; j++) begin
            mx         = j[0] ? r_a.second[0][CW-1:0] : r_a.first[0][CW-1:0];
            my         = j[1] ? r_a.second[1][CW-1:0] : r_a.first[1][CW-1:0];
            n_b.pxy[j] = PW'(mx) * PW'(my);
        end
    end

    // Stage C: volume of every sub-box.
    always_comb begin
        mz           = '0;
        n_c.action   = r_b.action;
        n_c.start    = r_b.start;
        n_c.start_hi = r_b.start_hi;
        n_c.len      = r_b.len;
        n_c.first    = r_b.first;
        n_c.second   = r_b.second;
        n_c.base     = r_b.base;
        n_c.level    = r_b.level;
        for (int k = 0; k < NUM_SUB; k++) begin
            mz         = k[2] ? r_b.second[2][CW-1:0] : r_b.first[2][CW-1:0];
            n_c.vol[k] = MORTON_W'(VW'(r_b.pxy[k[1:0]]) * VW'(mz));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_adv) begin
                r_a_valid <= accept && code_ok;
            end
            if (b_adv) begin
                r_b_valid <= r_a_valid;
            end
            if (c_adv) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && accept) begin
            r_a <= n_a;
        end
        if (b_adv && r_a_valid) begin
            r_b <= n_b;
        end
        if (c_adv && r_b_valid) begin
            r_c <= n_c;
        end
    end

    sps_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_c_valid),
        .i_box          (r_c),
        .o_free         (e_free),
        .o_strobe       (o_strobe),
        .o_subset_index (o_subset_index),
        .o_sub_start_x  (o_sub_start_x),
        .o_sub_start_y  (o_sub_start_y),
        .o_sub_start_z  (o_sub_start_z),
        .o_sub_length_x (o_sub_length_x),
        .o_sub_length_y (o_sub_length_y),
        .o_sub_length_z (o_sub_length_z),
        .o_sub_morton   (o_sub_morton),
        .o_sub_level    (o_sub_level),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
